// File: rtl/qvr_pkg.sv
package qvr_pkg;

   // Default component width and quaternion fraction bits (Q2.14)
   localparam int COMP_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

endpackage

// File: rtl/quaternion_vector_rotate.sv
// Rotates v by q * (0,v) * conj(q); five register stages, no stall loss.
// Throughput: one request per cycle unless rsp_stall backs up; a full stage holds only while its successor holds.
// Stages: q*v products, p sums, p*conj(q) products, r sums, round/saturate.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
module quaternion_vector_rotate
   import qvr_pkg::*;
#(
   parameter int COMP_WIDTH = COMP_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COMP_WIDTH-1:0] req_quat_w,
   input  logic signed [COMP_WIDTH-1:0] req_quat_x,
   input  logic signed [COMP_WIDTH-1:0] req_quat_y,
   input  logic signed [COMP_WIDTH-1:0] req_quat_z,
   input  logic signed [COMP_WIDTH-1:0] req_vec_x,
   input  logic signed [COMP_WIDTH-1:0] req_vec_y,
   input  logic signed [COMP_WIDTH-1:0] req_vec_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COMP_WIDTH-1:0] rsp_rot_x,
   output logic signed [COMP_WIDTH-1:0] rsp_rot_y,
   output logic signed [COMP_WIDTH-1:0] rsp_rot_z,
   output logic                         rsp_clipped
);

   localparam int W   = COMP_WIDTH;
   localparam int M1W = 2 * W;        // q * v product
   localparam int PW  = 2 * W + 2;    // p component, sum of three products
   localparam int M2W = PW + W;       // p * q product
   localparam int RW  = M2W + 2;      // r component, sum of four products

   // stage valid bits and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5;

   // stage 1: q*v products and quaternion
   logic signed [M1W-1:0] m1_ff [12];
   logic signed [W-1:0]   q1_ff [4];
   // stage 2: p = q * (0,v)
   logic signed [PW-1:0]  p_in  [4];
   logic signed [PW-1:0]  p_ff  [4];
   logic signed [W-1:0]   q2_ff [4];
   // stage 3: p*q products
   logic signed [M2W-1:0] m2_ff [12];
   // stage 4: vector part of r = p * conj(q)
   logic signed [RW-1:0]  r_in  [3];
   logic signed [RW-1:0]  r_ff  [3];
   // stage 5: rounded and saturated
   logic signed [W-1:0]   rot_in [3];
   logic                  clip  [3];
   logic signed [W-1:0]   rot_ff [3];
   logic                  clipped_ff;

   assign en5 = !rsp_valid_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff        <= req_valid;
         if (en2) v2_ff        <= v1_ff;
         if (en3) v3_ff        <= v2_ff;
         if (en4) v4_ff        <= v3_ff;
         if (en5) rsp_valid_ff <= v4_ff;
      end
   end

   // p0 = -xX - yY - zZ ; p1 = wX + yZ - zY ; p2 = wY - xZ + zX ; p3 = wZ + xY - yX
   always_comb begin
      p_in[0] = -PW'(m1_ff[0]) - PW'(m1_ff[1]) - PW'(m1_ff[2]);
      p_in[1] =  PW'(m1_ff[3]) + PW'(m1_ff[4]) - PW'(m1_ff[5]);
      p_in[2] =  PW'(m1_ff[6]) - PW'(m1_ff[7]) + PW'(m1_ff[8]);
      p_in[3] =  PW'(m1_ff[9]) + PW'(m1_ff[10]) - PW'(m1_ff[11]);
   end

   // r1 = -p0x + p1w - p2z + p3y ; r2 = -p0y + p1z + p2w - p3x ; r3 = -p0z - p1y + p2x + p3w
   always_comb begin
      r_in[0] = -RW'(m2_ff[0]) + RW'(m2_ff[1]) - RW'(m2_ff[2])  + RW'(m2_ff[3]);
      r_in[1] = -RW'(m2_ff[4]) + RW'(m2_ff[5]) + RW'(m2_ff[6])  - RW'(m2_ff[7]);
      r_in[2] = -RW'(m2_ff[8]) - RW'(m2_ff[9]) + RW'(m2_ff[10]) + RW'(m2_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         m1_ff[0]  <= M1W'(req_quat_x) * M1W'(req_vec_x);
         m1_ff[1]  <= M1W'(req_quat_y) * M1W'(req_vec_y);
         m1_ff[2]  <= M1W'(req_quat_z) * M1W'(req_vec_z);
         m1_ff[3]  <= M1W'(req_quat_w) * M1W'(req_vec_x);
         m1_ff[4]  <= M1W'(req_quat_y) * M1W'(req_vec_z);
         m1_ff[5]  <= M1W'(req_quat_z) * M1W'(req_vec_y);
         m1_ff[6]  <= M1W'(req_quat_w) * M1W'(req_vec_y);
         m1_ff[7]  <= M1W'(req_quat_x) * M1W'(req_vec_z);
         m1_ff[8]  <= M1W'(req_quat_z) * M1W'(req_vec_x);
         m1_ff[9]  <= M1W'(req_quat_w) * M1W'(req_vec_z);
         m1_ff[10] <= M1W'(req_quat_x) * M1W'(req_vec_y);
         m1_ff[11] <= M1W'(req_quat_y) * M1W'(req_vec_x);
         q1_ff[0]  <= req_quat_w;
         q1_ff[1]  <= req_quat_x;
         q1_ff[2]  <= req_quat_y;
         q1_ff[3]  <= req_quat_z;
      end
      if (en2) begin
         p_ff  <= p_in;
         q2_ff <= q1_ff;
      end
      if (en3) begin
         m2_ff[0]  <= M2W'(p_ff[0]) * M2W'(q2_ff[1]);
         m2_ff[1]  <= M2W'(p_ff[1]) * M2W'(q2_ff[0]);
         m2_ff[2]  <= M2W'(p_ff[2]) * M2W'(q2_ff[3]);
         m2_ff[3]  <= M2W'(p_ff[3]) * M2W'(q2_ff[2]);
         m2_ff[4]  <= M2W'(p_ff[0]) * M2W'(q2_ff[2]);
         m2_ff[5]  <= M2W'(p_ff[1]) * M2W'(q2_ff[3]);
         m2_ff[6]  <= M2W'(p_ff[2]) * M2W'(q2_ff[0]);
         m2_ff[7]  <= M2W'(p_ff[3]) * M2W'(q2_ff[1]);
         m2_ff[8]  <= M2W'(p_ff[0]) * M2W'(q2_ff[3]);
         m2_ff[9]  <= M2W'(p_ff[1]) * M2W'(q2_ff[2]);
         m2_ff[10] <= M2W'(p_ff[2]) * M2W'(q2_ff[1]);
         m2_ff[11] <= M2W'(p_ff[3]) * M2W'(q2_ff[0]);
      end
      if (en4) begin
         r_ff <= r_in;
      end
      if (en5) begin
         rot_ff     <= rot_in;
         clipped_ff <= clip[0] || clip[1] || clip[2];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_sat
      qvr_round_sat #(
         .COMP_WIDTH (COMP_WIDTH),
         .FRAC_BITS  (FRAC_BITS),
         .SUM_WIDTH  (RW)
      ) u_round_sat (
         .value  (r_ff[i]),
         .result (rot_in[i]),
         .clip   (clip[i])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_rot_x   = rot_ff[0];
   assign rsp_rot_y   = rot_ff[1];
   assign rsp_rot_z   = rot_ff[2];
   assign rsp_clipped = clipped_ff;

`ifndef NO_ASSERTIONS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("accepted request did not enter the first stage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff)
      else $error("request stalled while the pipeline has a free stage");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("last stage did not move into an empty output register");
`endif

endmodule

// File: rtl/qvr_round_sat.sv
module qvr_round_sat
   import qvr_pkg::*;
#(
   parameter int COMP_WIDTH = COMP_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int SUM_WIDTH  = 3 * COMP_WIDTH_DEF + 4
) (
   input  logic signed [SUM_WIDTH-1:0]  value,
   output logic signed [COMP_WIDTH-1:0] result,
   output logic                         clip
);

   localparam int SHIFT = 2 * FRAC_BITS;
   localparam int EXT_W = SUM_WIDTH + SHIFT;
   localparam int QW    = SUM_WIDTH + 1;

   logic signed [EXT_W-1:0]     ext;
   logic        [SUM_WIDTH-1:0] quo;
   logic        [QW-1:0]        rnd;
   logic                        pos_ovf;
   logic                        neg_ovf;

   // floor(v / 2^k) plus bit k-1 equals floor((v + 2^(k-1)) / 2^k)
   assign ext = EXT_W'(value);
   assign quo = ext[EXT_W-1:SHIFT];
   assign rnd = {quo[SUM_WIDTH-1], quo} + {{SUM_WIDTH{1'b0}}, ext[SHIFT-1]};

   assign pos_ovf = !rnd[QW-1] && (|rnd[QW-2:COMP_WIDTH-1]);
   assign neg_ovf = rnd[QW-1] && !(&rnd[QW-2:COMP_WIDTH-1]);
   assign clip    = pos_ovf || neg_ovf;

   always_comb begin
      if (pos_ovf) begin
         result = {1'b0, {(COMP_WIDTH-1){1'b1}}};
      end else if (neg_ovf) begin
         result = {1'b1, {(COMP_WIDTH-1){1'b0}}};
      end else begin
         result = rnd[COMP_WIDTH-1:0];
      end
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import qvr_pkg::*;

   localparam int CW = COMP_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam longint SAT_HI = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) <<< (CW - 1));
   localparam int RANDOM_PER_PHASE = 500;
   localparam int SETTLE_CYCLES = 16;
   localparam int HANG_LIMIT = 2000;

   typedef struct packed {
      logic signed [CW-1:0] quat_w;
      logic signed [CW-1:0] quat_x;
      logic signed [CW-1:0] quat_y;
      logic signed [CW-1:0] quat_z;
      logic signed [CW-1:0] vec_x;
      logic signed [CW-1:0] vec_y;
      logic signed [CW-1:0] vec_z;
   } rot_request_type;

   typedef struct packed {
      logic signed [CW-1:0] rot_x;
      logic signed [CW-1:0] rot_y;
      logic signed [CW-1:0] rot_z;
      logic                 clipped;
   } rot_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [CW-1:0] req_quat_w = '0;
   logic signed [CW-1:0] req_quat_x = '0;
   logic signed [CW-1:0] req_quat_y = '0;
   logic signed [CW-1:0] req_quat_z = '0;
   logic signed [CW-1:0] req_vec_x = '0;
   logic signed [CW-1:0] req_vec_y = '0;
   logic signed [CW-1:0] req_vec_z = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [CW-1:0] rsp_rot_x;
   logic signed [CW-1:0] rsp_rot_y;
   logic signed [CW-1:0] rsp_rot_z;
   logic                 rsp_clipped;

   rot_request_type pending_reqs[$];
   rot_result_type  expected_rots[$];
   bit              req_taken = 1'b0;
   int              send_idle_pct = 13;
   int              rsp_stall_pct = 50;
   int              idle_cycles = 0;
   int              mismatches = 0;
   int              accepted_reqs = 0;
   int              checked_rsps = 0;
   int              clipped_rsps = 0;

   quaternion_vector_rotate uut (.*);

   always #5 clock = ~clock;

   // Round half up by 2^(2*FB), then clamp; top bit flags a clamp.
   function automatic logic [CW:0] round_sat(input longint v);
      longint s;
      s = (v + (longint'(1) <<< (2 * FB - 1))) >>> (2 * FB);
      if (s > SAT_HI) return {1'b1, SAT_HI[CW-1:0]};
      if (s < SAT_LO) return {1'b1, SAT_LO[CW-1:0]};
      return {1'b0, s[CW-1:0]};
   endfunction

   // r = q * (0,v) * conj(q), exact in 64 bits (|r| stays under 2^50)
   function automatic rot_result_type predict_rotation(input rot_request_type rq);
      longint         w, x, y, z, vx, vy, vz;
      longint         pw, px, py, pz;
      logic [CW:0]    sx, sy, sz;
      rot_result_type res;
      w  = $signed(rq.quat_w);
      x  = $signed(rq.quat_x);
      y  = $signed(rq.quat_y);
      z  = $signed(rq.quat_z);
      vx = $signed(rq.vec_x);
      vy = $signed(rq.vec_y);
      vz = $signed(rq.vec_z);
      pw = -x * vx - y * vy - z * vz;
      px = w * vx + y * vz - z * vy;
      py = w * vy - x * vz + z * vx;
      pz = w * vz + x * vy - y * vx;
      sx = round_sat(-pw * x + px * w - py * z + pz * y);
      sy = round_sat(-pw * y + px * z + py * w - pz * x);
      sz = round_sat(-pw * z - px * y + py * x + pz * w);
      res.rot_x   = sx[CW-1:0];
      res.rot_y   = sy[CW-1:0];
      res.rot_z   = sz[CW-1:0];
      res.clipped = sx[CW] | sy[CW] | sz[CW];
      return res;
   endfunction

   function automatic rot_request_type make_request(input int w, input int x, input int y,
                                                    input int z, input int vx, input int vy,
                                                    input int vz);
      rot_request_type rq;
      rq.quat_w = w[CW-1:0];
      rq.quat_x = x[CW-1:0];
      rq.quat_y = y[CW-1:0];
      rq.quat_z = z[CW-1:0];
      rq.vec_x  = vx[CW-1:0];
      rq.vec_y  = vy[CW-1:0];
      rq.vec_z  = vz[CW-1:0];
      return rq;
   endfunction

   // Mix of raw random, unit-norm rotations and tiny values near rounding ties.
   function automatic rot_request_type random_request();
      rot_request_type rq;
      int              mode, vmax;
      real             a, b, c, d, n;
      mode = $urandom_range(9);
      rq.quat_w = CW'($urandom);
      rq.quat_x = CW'($urandom);
      rq.quat_y = CW'($urandom);
      rq.quat_z = CW'($urandom);
      rq.vec_x  = CW'($urandom);
      rq.vec_y  = CW'($urandom);
      rq.vec_z  = CW'($urandom);
      if (mode >= 4 && mode <= 8) begin
         a = real'(int'($urandom_range(32768)) - 16384);
         b = real'(int'($urandom_range(32768)) - 16384);
         c = real'(int'($urandom_range(32768)) - 16384);
         d = real'(int'($urandom_range(32768)) - 16384);
         n = $sqrt(a * a + b * b + c * c + d * d);
         if (n < 1.0) begin
            a = 1.0;
            n = 1.0;
         end
         rq.quat_w = CW'(int'(a * 16384.0 / n));
         rq.quat_x = CW'(int'(b * 16384.0 / n));
         rq.quat_y = CW'(int'(c * 16384.0 / n));
         rq.quat_z = CW'(int'(d * 16384.0 / n));
         if (mode == 8) begin
            vmax = 1 << $urandom_range(1, 10);
            rq.vec_x = CW'(int'($urandom_range(2 * vmax)) - vmax);
            rq.vec_y = CW'(int'($urandom_range(2 * vmax)) - vmax);
            rq.vec_z = CW'(int'($urandom_range(2 * vmax)) - vmax);
         end
      end else if (mode == 9) begin
         rq.quat_w = CW'(int'($urandom_range(2)) * 8192 - 8192);
         rq.quat_x = CW'(int'($urandom_range(2)) * 8192 - 8192);
         rq.quat_y = CW'(int'($urandom_range(2)) * 8192 - 8192);
         rq.quat_z = CW'(int'($urandom_range(2)) * 8192 - 8192);
         rq.vec_x  = CW'(int'($urandom_range(16)) - 8);
         rq.vec_y  = CW'(int'($urandom_range(16)) - 8);
         rq.vec_z  = CW'(int'($urandom_range(16)) - 8);
      end
      return rq;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rots.size() != 0)
         @(posedge clock);
   endtask

   always @(negedge clock) begin : drive_ports
      rot_request_type nxt;
      logic            drive;
      // a stalled request holds its payload and valid
      drive = req_valid && !req_taken;
      if (!drive && !reset && pending_reqs.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
         nxt = pending_reqs.pop_front();
         req_quat_w <= nxt.quat_w;
         req_quat_x <= nxt.quat_x;
         req_quat_y <= nxt.quat_y;
         req_quat_z <= nxt.quat_z;
         req_vec_x  <= nxt.vec_x;
         req_vec_y  <= nxt.vec_y;
         req_vec_z  <= nxt.vec_z;
         drive = 1'b1;
      end
      req_valid <= drive;
      req_taken = 1'b0;
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin : watch_ports
      rot_request_type rq;
      rot_result_type  got, want;
      logic            progress;
      progress = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         rq = '{req_quat_w, req_quat_x, req_quat_y, req_quat_z,
                req_vec_x, req_vec_y, req_vec_z};
         expected_rots.push_back(predict_rotation(rq));
         req_taken = 1'b1;
         accepted_reqs++;
         progress = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         progress = 1'b1;
         got = '{rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_clipped};
         if (expected_rots.size() == 0) begin
            $error("unexpected result: rot_x %0d rot_y %0d rot_z %0d clipped %0d",
                   got.rot_x, got.rot_y, got.rot_z, got.clipped);
            mismatches++;
         end else begin
            want = expected_rots.pop_front();
            check_field("rot_x", $signed(want.rot_x), $signed(got.rot_x));
            check_field("rot_y", $signed(want.rot_y), $signed(got.rot_y));
            check_field("rot_z", $signed(want.rot_z), $signed(got.rot_z));
            check_field("clipped", want.clipped, got.clipped);
            checked_rsps++;
            if (want.clipped) clipped_rsps++;
         end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
   end

   initial begin : hang_watch
      wait (idle_cycles >= HANG_LIMIT);
      $display("timeout: no request moved for %0d cycles", HANG_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : run_test
      int n;
      int phase;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity, negated identity and zero quaternion
      pending_reqs.push_back(make_request(16384, 0, 0, 0, 1, 2, 3));
      pending_reqs.push_back(make_request(16384, 0, 0, 0, 32767, -32768, 0));
      pending_reqs.push_back(make_request(-16384, 0, 0, 0, -5, 7, -9));
      pending_reqs.push_back(make_request(0, 0, 0, 0, 32767, -32768, 12345));
      // quarter turns about z and x, half turns about each axis
      pending_reqs.push_back(make_request(11585, 0, 0, 11585, 1000, 0, 0));
      pending_reqs.push_back(make_request(11585, 11585, 0, 0, 0, -20000, 300));
      pending_reqs.push_back(make_request(0, 16384, 0, 0, 100, 200, 300));
      pending_reqs.push_back(make_request(0, 0, 16384, 0, 100, 200, 300));
      pending_reqs.push_back(make_request(0, 0, 0, 16384, 100, 200, 300));
      // field extremes: saturate high and low
      pending_reqs.push_back(make_request(32767, 32767, 32767, 32767, 32767, 32767, 32767));
      pending_reqs.push_back(make_request(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768));
      pending_reqs.push_back(make_request(-32768, 32767, -32768, 32767,
                                          32767, -32768, 32767));
      pending_reqs.push_back(make_request(32767, 0, 0, 0, 16384, -16384, 8192));
      pending_reqs.push_back(make_request(-32768, 0, 0, 0, 8191, -8193, 8192));
      // half-scale quaternion: results land on or near rounding ties
      pending_reqs.push_back(make_request(8192, 0, 0, 0, 2, -2, 6));
      pending_reqs.push_back(make_request(8192, 0, 0, 0, -6, 1, -1));
      pending_reqs.push_back(make_request(1, 1, 1, 1, 1, -1, 1));
      pending_reqs.push_back(make_request(-1, -1, -1, -1, 32767, 0, -32768));
      pending_reqs.push_back(make_request(9459, 9459, 9459, 9459, 30000, -30000, 30000));

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 50 : 0;
         rsp_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 13 : 0;
         for (n = 0; n < RANDOM_PER_PHASE; n++)
            pending_reqs.push_back(random_request());
         // wait until every queued request has been sent and checked
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Rotated %0d requests (directed axes, ties, extremes, unit and raw random),",
               accepted_reqs);
      $display("checked %0d results, %0d of them clamped, under three stall mixes.",
               checked_rsps, clipped_rsps);
      if (mismatches == 0 && expected_rots.size() == 0 && checked_rsps == accepted_reqs) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
